/* rtl/core/hsd_pkg.sv */
// Shared types and constants of the motion hysteresis and stop detector.
`default_nettype none
package hsd_pkg;

	localparam int SPEED_W  = 24;
	localparam int SCALE_W  = 12;
	localparam int HOLD_W   = 16;
	localparam int COUNT_W  = 8;
	localparam int AGE_W    = 32;
	localparam int DROP_W   = 9;
	localparam int WLEN_W   = 5;
	localparam int CMD_W    = 2;
	localparam int PROD_W   = SPEED_W + SCALE_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 40;

	localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(256);
	localparam logic [SPEED_W-1:0] SPEED_ONE = SPEED_W'(256);

	typedef enum logic [CMD_W-1:0] {
		CMD_UPDATE     = 2'd0,
		CMD_STOP_CHECK = 2'd1,
		CMD_RAISE      = 2'd2,
		CMD_SOFT_RESET = 2'd3
	} cmd_t;

	localparam logic [CFG_IDX_W-1:0] REG_ENTER    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXIT     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WLEN     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DROP     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN = 3'd5;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EXEC = 5'b00010,
		ST_UPD  = 5'b00100,
		ST_SCAN = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

endpackage
`default_nettype wire

/* rtl/core/hsd_mul.sv */
// Shared registered multiplier for the exit threshold scale and the drop fraction.
`default_nettype none
module hsd_mul
	import hsd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic [SPEED_W-1:0] a,
	input  wire logic [SCALE_W-1:0] b,
	output logic      [PROD_W-1:0]  prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(a) * PROD_W'(b);
	end

endmodule
`default_nettype wire

/* rtl/core/hsd_win_mem.sv */
// Speed window memory: one write port, one registered read port.
`default_nettype none
module hsd_win_mem
	import hsd_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [SPEED_W-1:0]       wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [SPEED_W-1:0]       rdata
);

	logic [SPEED_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

/* rtl/core/motion_hysteresis_stop_detector.sv */
// Top level: still/moving classifier with hysteresis and sudden-stop window check.
`default_nettype none
// One item at a time. An update passes the execute state (operand select, one pass through
// the shared multiplier), the update state (hysteresis compare) and the done state (output
// load); raise and soft reset go from execute straight to done. A stop check that scans
// reads the effective window length of entries from the window memory, one per cycle, and
// each step goes through the same multiplier and one compare. A check during cooldown, one
// that leaves the window short, or one on a single-entry window goes from execute straight
// to done. A finished result waits in the output register and the next item can be accepted
// meanwhile; its result is held until the output register drains. No clearing pass follows reset.
module motion_hysteresis_stop_detector
	import hsd_pkg::*;
#(
	parameter int WINDOW_MAX = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,   // speed, multiplier, hold_frames, zero fill
	input  wire logic [CMD_W-1:0]      s_tuser,   // command
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic      [OUT_DATA_W-1:0] m_tdata,   // moving, stop_seen, frames_in_state, zero fill
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = $clog2(WINDOW_MAX);
	localparam int CW = $clog2(WINDOW_MAX + 1);

	// configuration
	logic [SPEED_W-1:0] enter_q;
	logic [SPEED_W-1:0] exit_q;
	logic [COUNT_W-1:0] minf_q;
	logic [WLEN_W-1:0]  wlen_q;
	logic [DROP_W-1:0]  drop_q;
	logic [HOLD_W-1:0]  cool_cfg_q;

	// latched item
	cmd_t               cmd_q;
	logic [SPEED_W-1:0] speed_q;
	logic [SCALE_W-1:0] mult_q;
	logic [HOLD_W-1:0]  hold_q;

	// detector state
	state_t             st_q;
	logic               motion_q;
	logic [COUNT_W-1:0] qc_q;
	logic [AGE_W-1:0]   age_q;
	logic [SCALE_W-1:0] scale_q;
	logic [HOLD_W-1:0]  tcount_q;
	logic [HOLD_W-1:0]  cool_q;
	logic [CW-1:0]      fill_q;
	logic [AW-1:0]      wp_q;
	logic               stop_q;

	// scan
	logic [AW-1:0]      rp_q;
	logic [CW-1:0]      iss_q;
	logic [CW-1:0]      got_q;
	logic               rd_vld_s1;
	logic [SPEED_W-1:0] prev_q;
	logic               fail_q;

	// output register
	logic               m_valid_q;
	logic               out_moving_q;
	logic               out_stop_q;
	logic [AGE_W-1:0]   out_age_q;

	logic [SPEED_W-1:0] mul_a;
	logic [SCALE_W-1:0] mul_b;
	logic [PROD_W-1:0]  prod_q;
	logic               mem_we;
	logic               mem_re;
	logic [SPEED_W-1:0] rdata;

	logic [CW-1:0]      len_eff;
	logic [CW:0]        fill_sum;
	logic [CW-1:0]      fill_nx;
	logic [AW-1:0]      wp_nx;
	logic [CW:0]        start_wrap;
	logic [AW-1:0]      start_ptr;
	logic               qual;
	logic [COUNT_W-1:0] qc_sat;
	logic               flip;
	logic [PROD_W-1:0]  step_lhs;
	logic [PROD_W-1:0]  step_rhs;
	logic               fail_now;
	logic               scan_last;
	logic               in_acc;
	logic               out_free;
	logic               out_load;

	assign s_tready = (st_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;
	assign out_free = !m_valid_q || m_tready;
	assign out_load = (st_q == ST_DONE) && out_free;
	assign m_tdata  = {(OUT_DATA_W - AGE_W - 2)'(0), out_age_q, out_stop_q, out_moving_q};

	always_comb begin
		if (wlen_q == '0) begin
			len_eff = CW'(1);
		end else if (32'(wlen_q) > WINDOW_MAX) begin
			len_eff = CW'(WINDOW_MAX);
		end else begin
			len_eff = CW'(wlen_q);
		end
	end

	// window bookkeeping for a push
	always_comb begin
		fill_sum = (CW+1)'(fill_q) + (CW+1)'(1);
		fill_nx  = (fill_sum > (CW+1)'(len_eff)) ? len_eff : fill_sum[CW-1:0];
		wp_nx    = (32'(wp_q) == WINDOW_MAX - 1) ? '0 : wp_q + AW'(1);
		start_wrap = (CW+1)'(wp_nx) + (CW+1)'(WINDOW_MAX) - (CW+1)'(len_eff);
		if ((CW+1)'(wp_nx) >= (CW+1)'(len_eff)) begin
			start_ptr = AW'((CW+1)'(wp_nx) - (CW+1)'(len_eff));
		end else begin
			start_ptr = AW'(start_wrap);
		end
	end

	// shared multiplier operands
	always_comb begin
		if (st_q == ST_SCAN) begin
			mul_a = rdata;
			mul_b = SCALE_W'(drop_q);
		end else begin
			mul_a = exit_q;
			mul_b = scale_q;
		end
	end

	assign mem_we = (st_q == ST_EXEC) && (cmd_q == CMD_STOP_CHECK) && (cool_q == '0);
	assign mem_re = (st_q == ST_SCAN) && (iss_q < len_eff);

	// hysteresis compare and counter
	always_comb begin
		if (motion_q) begin
			qual = (PROD_W'(speed_q) << 8) < prod_q;
		end else begin
			qual = speed_q > enter_q;
		end
		qc_sat = (qc_q == '1) ? qc_q : qc_q + COUNT_W'(1);
		flip   = qual && (qc_sat >= minf_q);
	end

	// drop step compare: prod_q holds drop_fraction * prev_q
	always_comb begin
		step_lhs  = PROD_W'(prev_q) << 8;
		step_rhs  = prod_q + (PROD_W'(rdata) << 8);
		fail_now  = (prev_q < SPEED_ONE) || (step_lhs < step_rhs);
		scan_last = rd_vld_s1 && (got_q == len_eff - CW'(1));
	end

	hsd_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	hsd_win_mem #(
		.DEPTH (WINDOW_MAX)
	) u_win (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wp_q),
		.wdata (speed_q),
		.re    (mem_re),
		.raddr (rp_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enter_q    <= '0;
			exit_q     <= '0;
			minf_q     <= COUNT_W'(1);
			wlen_q     <= WLEN_W'(3);
			drop_q     <= DROP_W'(77);
			cool_cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENTER:    enter_q    <= cfg_data[SPEED_W-1:0];
				REG_EXIT:     exit_q     <= cfg_data[SPEED_W-1:0];
				REG_MIN:      minf_q     <= cfg_data[COUNT_W-1:0];
				REG_WLEN:     wlen_q     <= cfg_data[WLEN_W-1:0];
				REG_DROP:     drop_q     <= cfg_data[DROP_W-1:0];
				REG_COOLDOWN: cool_cfg_q <= cfg_data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q   <= cmd_t'(s_tuser);
			speed_q <= s_tdata[SPEED_W-1:0];
			mult_q  <= s_tdata[SPEED_W +: SCALE_W];
			hold_q  <= s_tdata[SPEED_W + SCALE_W +: HOLD_W];
		end
		if (st_q == ST_SCAN && rd_vld_s1) begin
			prev_q <= rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			motion_q     <= 1'b0;
			qc_q         <= '0;
			age_q        <= '0;
			scale_q      <= SCALE_ONE;
			tcount_q     <= '0;
			cool_q       <= '0;
			fill_q       <= '0;
			wp_q         <= '0;
			stop_q       <= 1'b0;
			rp_q         <= '0;
			iss_q        <= '0;
			got_q        <= '0;
			rd_vld_s1    <= 1'b0;
			fail_q       <= 1'b0;
			m_valid_q    <= 1'b0;
			out_moving_q <= 1'b0;
			out_stop_q   <= 1'b0;
			out_age_q    <= '0;
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			rd_vld_s1 <= mem_re;
			case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						stop_q <= 1'b0;
						st_q   <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					case (cmd_q)
						CMD_UPDATE: begin
							st_q <= ST_UPD;
						end
						CMD_STOP_CHECK: begin
							if (cool_q == '0) begin
								wp_q <= wp_nx;
								if (fill_nx < len_eff) begin
									fill_q <= fill_nx;
									st_q   <= ST_DONE;
								end else if (len_eff == CW'(1)) begin
									// single-entry window flags at once
									fill_q <= '0;
									cool_q <= cool_cfg_q;
									stop_q <= 1'b1;
									st_q   <= ST_DONE;
								end else begin
									fill_q <= fill_nx;
									rp_q   <= start_ptr;
									iss_q  <= '0;
									got_q  <= '0;
									fail_q <= 1'b0;
									st_q   <= ST_SCAN;
								end
							end else begin
								st_q <= ST_DONE;
							end
						end
						CMD_RAISE: begin
							scale_q  <= mult_q;
							tcount_q <= hold_q;
							st_q     <= ST_DONE;
						end
						CMD_SOFT_RESET: begin
							motion_q <= 1'b0;
							qc_q     <= '0;
							age_q    <= '0;
							scale_q  <= SCALE_ONE;
							tcount_q <= '0;
							cool_q   <= '0;
							fill_q   <= '0;
							wp_q     <= '0;
							st_q     <= ST_DONE;
						end
						default: begin
							st_q <= ST_DONE;
						end
					endcase
				end
				ST_UPD: begin
					if (flip) begin
						motion_q <= !motion_q;
						qc_q     <= '0;
						age_q    <= '0;
					end else begin
						qc_q <= qual ? qc_sat : '0;
						if (age_q != '1) begin
							age_q <= age_q + AGE_W'(1);
						end
					end
					if (tcount_q != '0) begin
						tcount_q <= tcount_q - HOLD_W'(1);
						if (tcount_q == HOLD_W'(1)) begin
							scale_q <= SCALE_ONE;
						end
					end
					if (cool_q != '0) begin
						cool_q <= cool_q - HOLD_W'(1);
					end
					st_q <= ST_DONE;
				end
				ST_SCAN: begin
					// advance the read pointer one entry per cycle
					if (mem_re) begin
						iss_q <= iss_q + CW'(1);
						rp_q  <= (32'(rp_q) == WINDOW_MAX - 1) ? '0 : rp_q + AW'(1);
					end
					if (rd_vld_s1) begin
						got_q <= got_q + CW'(1);
						if (got_q != '0 && fail_now) begin
							fail_q <= 1'b1;
						end
					end
					if (scan_last) begin
						if (!fail_q && !fail_now) begin
							fill_q <= '0;
							cool_q <= cool_cfg_q;
							stop_q <= 1'b1;
						end
						st_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold until the output register is free
					if (out_load) begin
						out_moving_q <= motion_q;
						out_stop_q   <= stop_q;
						out_age_q    <= age_q;
						st_q         <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* test/motion_hysteresis_stop_detector_tb.sv */
// Testbench for the motion hysteresis and sudden-stop detector: random stream traffic, predicted status.
module motion_hysteresis_stop_detector_tb
	import hsd_pkg::*;
();

	localparam int WIN_DEPTH    = 16;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 30;
	localparam int PHASE_ITEMS  = 230;

	typedef struct {
		cmd_t               cmd;
		logic [SPEED_W-1:0] speed;
		logic [SCALE_W-1:0] mult;
		logic [HOLD_W-1:0]  hold;
	} sensor_item_t;

	typedef struct {
		logic             moving;
		logic             stop_seen;
		logic [AGE_W-1:0] age;
	} detector_status_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;    // speed, multiplier, hold_frames, zero fill
	logic [CMD_W-1:0]      s_tuser = CMD_UPDATE;    // command
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;         // moving, stop_seen, frames_in_state, zero fill
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	motion_hysteresis_stop_detector dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// Register copies, reset values
	logic [SPEED_W-1:0] enter_thr = '0;
	logic [SPEED_W-1:0] exit_thr = '0;
	logic [COUNT_W-1:0] min_qual = 8'd1;
	logic [WLEN_W-1:0]  win_len = 5'd3;
	logic [DROP_W-1:0]  drop_frac = 9'd77;
	logic [HOLD_W-1:0]  cooldown_len = '0;

	// Detector state
	logic               cur_moving;
	logic [COUNT_W-1:0] qual_cnt;
	logic [AGE_W-1:0]   age_cnt;
	logic [SCALE_W-1:0] exit_scale;
	logic [HOLD_W-1:0]  scale_left;
	logic [HOLD_W-1:0]  cooldown_left;
	logic [SPEED_W-1:0] speed_hist [WIN_DEPTH];
	int                 hist_fill;

	sensor_item_t     pending_items[$];
	detector_status_t status_due[$];
	sensor_item_t     held, nxt;
	detector_status_t got, want;
	int               bad_results = 0;
	int               tx_burst = 1, tx_gap = 0;
	int               rx_mode = 0, rx_left = 0, rx_period = 2, rx_phase = 0;
	logic             rx_ready;
	int               quiet_cycles = 0;
	logic [SCALE_W-1:0] gen_scale = SCALE_ONE;

	function automatic void clear_detector();
		cur_moving = 1'b0;
		qual_cnt = '0;
		age_cnt = '0;
		exit_scale = SCALE_ONE;
		scale_left = '0;
		cooldown_left = '0;
		for (int i = 0; i < WIN_DEPTH; i++)
			speed_hist[i] = '0;
		hist_fill = 0;
	endfunction

	function automatic int window_span();
		if (win_len == 0)
			return 1;
		if (win_len > WIN_DEPTH)
			return WIN_DEPTH;
		return int'(win_len);
	endfunction

	function automatic detector_status_t step_detector(input sensor_item_t it);
		detector_status_t st;
		logic             qualifies, flip, stop;
		int               len, i;
		logic [63:0]      older, newer;
		stop = 1'b0;
		case (it.cmd)
		CMD_UPDATE: begin
			if (!cur_moving)
				qualifies = it.speed > enter_thr;
			else
				qualifies = 64'(it.speed) * 64'd256 < 64'(exit_thr) * 64'(exit_scale);
			flip = 1'b0;
			if (qualifies) begin
				if (qual_cnt != '1)
					qual_cnt++;
				if (qual_cnt >= min_qual) begin
					flip = 1'b1;
					qual_cnt = '0;
				end
			end else begin
				qual_cnt = '0;
			end
			if (flip) begin
				cur_moving = !cur_moving;
				age_cnt = '0;
			end else if (age_cnt != '1) begin
				age_cnt++;
			end
			if (scale_left != 0) begin
				scale_left--;
				if (scale_left == 0)
					exit_scale = SCALE_ONE;
			end
			if (cooldown_left != 0)
				cooldown_left--;
		end
		CMD_STOP_CHECK: if (cooldown_left == 0) begin
			len = window_span();
			if (hist_fill < WIN_DEPTH) begin
				speed_hist[hist_fill] = it.speed;
				hist_fill++;
			end else begin
				for (i = 0; i < WIN_DEPTH - 1; i++)
					speed_hist[i] = speed_hist[i + 1];
				speed_hist[WIN_DEPTH - 1] = it.speed;
			end
			// keep only the newest entries after a shrink
			if (hist_fill > len) begin
				for (i = 0; i < len; i++)
					speed_hist[i] = speed_hist[i + hist_fill - len];
				hist_fill = len;
			end
			if (hist_fill == len) begin
				stop = 1'b1;
				for (i = 1; i < hist_fill; i++) begin
					older = 64'(speed_hist[i - 1]);
					newer = 64'(speed_hist[i]);
					if (older < 64'd256 ||
					    older * 64'd256 < 64'(drop_frac) * older + newer * 64'd256)
						stop = 1'b0;
				end
				if (stop) begin
					cooldown_left = cooldown_len;
					hist_fill = 0;
				end
			end
		end
		CMD_RAISE: begin
			exit_scale = it.mult;
			scale_left = it.hold;
		end
		default: clear_detector();
		endcase
		st.moving = cur_moving;
		st.stop_seen = stop;
		st.age = age_cnt;
		return st;
	endfunction

	// Sender: bursts of items separated by random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				held.cmd = cmd_t'(s_tuser);
				held.speed = s_tdata[SPEED_W-1:0];
				held.mult = s_tdata[SPEED_W +: SCALE_W];
				held.hold = s_tdata[SPEED_W + SCALE_W +: HOLD_W];
				status_due = {status_due, step_detector(held)};
			end
			if (!s_tvalid || s_tready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					nxt = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {{(IN_DATA_W - SPEED_W - SCALE_W - HOLD_W){1'b0}},
						nxt.hold, nxt.mult, nxt.speed};
					s_tuser <= nxt.cmd;
					if (tx_burst > 1) begin
						tx_burst--;
					end else begin
						tx_burst = int'($urandom_range(1, 40));
						tx_gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 12));
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: switch between stall patterns now and then
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = int'($urandom_range(0, 3));
				rx_left = int'($urandom_range(20, 300));
				rx_period = int'($urandom_range(2, 8));
				rx_phase = 0;
			end
			rx_left--;
			rx_phase = (rx_phase + 1) % rx_period;
			case (rx_mode)
			0: rx_ready = 1'b1;
			1: rx_ready = 1'($urandom_range(0, 1));
			2: rx_ready = (rx_phase == 0);
			default: rx_ready = ($urandom_range(0, 15) == 0);
			endcase
			m_tready <= rx_ready;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got.moving = m_tdata[0];
			got.stop_seen = m_tdata[1];
			got.age = m_tdata[2 +: AGE_W];
			if (status_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, got moving=%0b stop=%0b age=%0d",
					$time, got.moving, got.stop_seen, got.age);
				bad_results++;
			end else begin
				want = status_due.pop_front();
				if (got.moving !== want.moving) begin
					$display("%0t: moving mismatch, expected %0b, got %0b",
						$time, want.moving, got.moving);
					bad_results++;
				end
				if (got.stop_seen !== want.stop_seen) begin
					$display("%0t: stop_seen mismatch, expected %0b, got %0b",
						$time, want.stop_seen, got.stop_seen);
					bad_results++;
				end
				if (got.age !== want.age) begin
					$display("%0t: frames_in_state mismatch, expected %0d, got %0d",
						$time, want.age, got.age);
					bad_results++;
				end
			end
		end
	end

	// End the run when traffic is outstanding but nothing moves
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else if (pending_items.size() > 0 || s_tvalid || status_due.size() > 0)
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	function automatic logic [SPEED_W-1:0] sat_speed(input longint v);
		if (v < 0)
			return '0;
		if (v > longint'(24'hFFFFFF))
			return '1;
		return v[SPEED_W-1:0];
	endfunction

	task automatic queue_item(input cmd_t cmd, input logic [SPEED_W-1:0] speed,
		input logic [SCALE_W-1:0] mult, input logic [HOLD_W-1:0] hold);
		sensor_item_t it;
		it.cmd = cmd;
		it.speed = speed;
		it.mult = mult;
		it.hold = hold;
		pending_items = {pending_items, it};
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_items.size() > 0 || s_tvalid || status_due.size() > 0);
	endtask

	task automatic write_config(input logic [SPEED_W-1:0] enter_v, input logic [SPEED_W-1:0] exit_v,
		input logic [COUNT_W-1:0] min_v, input logic [WLEN_W-1:0] wlen_v,
		input logic [DROP_W-1:0] drop_v, input logic [HOLD_W-1:0] cool_v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_ENTER;
		cfg_data <= enter_v;
		@(posedge clk);
		cfg_index <= REG_EXIT;
		cfg_data <= exit_v;
		@(posedge clk);
		cfg_index <= REG_MIN;
		cfg_data <= CFG_DATA_W'(min_v);
		@(posedge clk);
		cfg_index <= REG_WLEN;
		cfg_data <= CFG_DATA_W'(wlen_v);
		@(posedge clk);
		cfg_index <= REG_DROP;
		cfg_data <= CFG_DATA_W'(drop_v);
		@(posedge clk);
		cfg_index <= REG_COOLDOWN;
		cfg_data <= CFG_DATA_W'(cool_v);
		@(posedge clk);
		cfg_we <= 1'b0;
		enter_thr = enter_v;
		exit_thr = exit_v;
		min_qual = min_v;
		win_len = wlen_v;
		drop_frac = drop_v;
		cooldown_len = cool_v;
	endtask

	// Mostly threshold-hugging updates and decaying stop-check runs, some noise
	task automatic queue_random_items(input int count);
		int                 added, pick, len, k;
		longint             prev, ceiling, step;
		logic [SPEED_W-1:0] base;
		added = 0;
		while (added < count) begin
			pick = int'($urandom_range(0, 99));
			if (pick < 45) begin
				case ($urandom_range(0, 3))
				0: base = enter_thr;
				1: base = sat_speed((longint'(exit_thr) * longint'(gen_scale)) >>> 8);
				2: base = SPEED_W'($urandom_range(0, 600));
				default: base = SPEED_W'($urandom);
				endcase
				queue_item(CMD_UPDATE,
					sat_speed(longint'(base) + longint'($urandom_range(0, 64)) - 32),
					SCALE_W'($urandom), HOLD_W'($urandom));
				added++;
			end else if (pick < 80) begin
				len = window_span();
				if ($urandom_range(0, 4) == 0)
					len = len + int'($urandom_range(0, 2)) - 1;
				prev = ($urandom_range(0, 3) == 0) ? longint'($urandom_range(0, 24'hFFFFFF))
					: longint'($urandom_range(24'h010000, 24'hFFFFFF));
				for (k = 0; k < len; k++) begin
					if ($urandom_range(0, 19) == 0)
						queue_item(CMD_STOP_CHECK, SPEED_W'($urandom), SCALE_W'($urandom),
							HOLD_W'($urandom));
					else
						queue_item(CMD_STOP_CHECK, sat_speed(prev), SCALE_W'($urandom),
							HOLD_W'($urandom));
					// largest next speed that still counts as a sharp enough drop
					ceiling = prev - ((longint'(drop_frac) * prev + 255) >>> 8);
					if (ceiling < 0)
						ceiling = 0;
					if ($urandom_range(0, 2) == 0) begin
						prev = longint'($urandom_range(0, int'(ceiling)));
					end else begin
						step = (ceiling < 3) ? ceiling : 3;
						prev = ceiling - longint'($urandom_range(0, int'(step)));
					end
				end
				added += len;
			end else if (pick < 90) begin
				gen_scale = ($urandom_range(0, 3) == 0) ? SCALE_W'($urandom_range(0, 4095))
					: SCALE_W'($urandom_range(128, 1024));
				queue_item(CMD_RAISE, SPEED_W'($urandom), gen_scale,
					($urandom_range(0, 4) == 0) ? HOLD_W'($urandom)
					: HOLD_W'($urandom_range(0, 20)));
				added++;
			end else if (pick < 94) begin
				gen_scale = SCALE_ONE;
				queue_item(CMD_SOFT_RESET, SPEED_W'($urandom), SCALE_W'($urandom),
					HOLD_W'($urandom));
				added++;
			end else begin
				queue_item(cmd_t'($urandom_range(0, 3)), SPEED_W'($urandom),
					SCALE_W'($urandom), HOLD_W'($urandom));
				added++;
			end
		end
	endtask

	initial begin
		clear_detector();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		write_config(24'd1000, 24'd800, 8'd0, 5'd3, 9'd77, 16'd2);
		queue_item(CMD_UPDATE, 24'hFFFFFF, 12'h000, 16'h0000);
		queue_item(CMD_UPDATE, 24'd0, 12'h000, 16'h0000);
		queue_item(CMD_UPDATE, 24'd2000, 12'h000, 16'h0000);
		// scaled exit threshold for two updates
		queue_item(CMD_RAISE, 24'd0, 12'hFFF, 16'd2);
		queue_item(CMD_UPDATE, 24'd5000, 12'h000, 16'h0000);
		queue_item(CMD_UPDATE, 24'd2000, 12'h000, 16'h0000);
		queue_item(CMD_UPDATE, 24'd900, 12'h000, 16'h0000);
		// zero scale held until soft reset: moving can never exit
		queue_item(CMD_RAISE, 24'd0, 12'h000, 16'd0);
		queue_item(CMD_UPDATE, 24'd0, 12'h000, 16'h0000);
		queue_item(CMD_SOFT_RESET, 24'hFFFFFF, 12'hFFF, 16'hFFFF);
		queue_item(CMD_STOP_CHECK, 24'h002000, 12'h000, 16'h0000);
		queue_item(CMD_STOP_CHECK, 24'h001000, 12'h000, 16'h0000);
		queue_item(CMD_STOP_CHECK, 24'h000800, 12'h000, 16'h0000);
		queue_item(CMD_STOP_CHECK, 24'd100, 12'h000, 16'h0000);
		queue_item(CMD_UPDATE, 24'd0, 12'h000, 16'h0000);
		queue_item(CMD_UPDATE, 24'd0, 12'h000, 16'h0000);
		// exact drop boundary, then an earlier speed below 1.0
		queue_item(CMD_STOP_CHECK, 24'd256, 12'h000, 16'h0000);
		queue_item(CMD_STOP_CHECK, 24'd179, 12'h000, 16'h0000);
		queue_item(CMD_STOP_CHECK, 24'd125, 12'h000, 16'h0000);
		// rising speeds
		queue_item(CMD_STOP_CHECK, 24'h000100, 12'h000, 16'h0000);
		queue_item(CMD_STOP_CHECK, 24'h000200, 12'h000, 16'h0000);
		queue_item(CMD_RAISE, 24'd0, 12'h100, 16'hFFFF);
		wait_idle();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
			0: write_config(24'd0, 24'hFFFFFF, 8'd0, 5'd1, 9'd0, 16'd0);
			1: write_config(24'd0, 24'hFFFFFF, 8'd255, 5'd16, 9'd256, 16'hFFFF);
			2: write_config(SPEED_W'($urandom), SPEED_W'($urandom),
				COUNT_W'($urandom_range(0, 3)), 5'd0, 9'h1FF, 16'd3);
			3: write_config(SPEED_W'($urandom), SPEED_W'($urandom), 8'd2, 5'd31,
				DROP_W'($urandom_range(0, 60)), 16'd1);
			default: write_config(SPEED_W'($urandom_range(0, 24'h00FFFF)),
				SPEED_W'($urandom_range(0, 24'h00FFFF)),
				COUNT_W'($urandom_range(0, 5)), WLEN_W'($urandom_range(1, 16)),
				DROP_W'($urandom_range(0, 256)), HOLD_W'($urandom_range(0, 12)));
			endcase
			if (ph == 1) begin
				// long qualifying runs: count up to the top of min_frames and flip
				queue_item(CMD_SOFT_RESET, 24'd0, 12'h000, 16'h0000);
				for (int n = 0; n < 300; n++)
					queue_item(CMD_UPDATE, SPEED_W'($urandom_range(1, 24'hFFFFFE)),
						SCALE_W'($urandom), HOLD_W'($urandom));
			end else begin
				queue_random_items(PHASE_ITEMS);
			end
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (bad_results == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* files.f */
rtl/core/hsd_pkg.sv
rtl/core/hsd_mul.sv
rtl/core/hsd_win_mem.sv
rtl/core/motion_hysteresis_stop_detector.sv
test/motion_hysteresis_stop_detector_tb.sv
